// ----- design/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcd_pkg
// Shared types and constants of the gain command decoder: character codes,
// command table, status codes and the record passed from parser to issuer.
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam int unsigned CMD_CHARS   = 3;
	localparam int unsigned CMD_ENTRIES = 5;
	localparam int unsigned DIGIT_MAX   = 31;
	localparam int unsigned QUEUE_DEPTH = 2;

	// command strings, first character in the top byte
	localparam logic [23:0] CMD_TABLE [CMD_ENTRIES] = '{
		{8'h4B, 8'h70, 8'h31},	// Kp1
		{8'h4B, 8'h70, 8'h32},	// Kp2
		{8'h4B, 8'h69, 8'h31},	// Ki1
		{8'h4B, 8'h69, 8'h32},	// Ki2
		{8'h58, 8'h2A, 8'h2A}	// X**
	};
	localparam logic [1:0] CMD_GAIN [CMD_ENTRIES] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3};

	localparam logic [1:0] ST_ACCEPTED    = 2'd0;
	localparam logic [1:0] ST_UNKNOWN_CMD = 2'd1;
	localparam logic [1:0] ST_BAD_NUMBER  = 2'd2;

	typedef struct packed {
		logic        known;
		logic [1:0]  sel;
	} cmd_match_t;

	// classified message, handed from the parser to the issuer
	typedef struct packed {
		logic        known;
		logic [1:0]  sel;
		logic        num_ok;
		logic [31:0] value;
	} cmd_rec_t;

	function automatic cmd_match_t cmd_lookup(input logic [23:0] chars);
		cmd_match_t m;
		m = '0;
		for (int i = CMD_ENTRIES - 1; i >= 0; i--) begin
			if (chars == CMD_TABLE[i]) begin
				m.known = 1'b1;
				m.sel   = CMD_GAIN[i];
			end
		end
		return m;
	endfunction

endpackage

// ----- design/gcd_queue.sv -----
// ----------------------------------------------------------------------------
// gcd_queue
// Small register queue between the parser and the issuer.
// ----------------------------------------------------------------------------
module gcd_queue #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/gcd_parser.sv -----
// ----------------------------------------------------------------------------
// gcd_parser
// Front end: takes one message byte per cycle while take is high, tracks command and number,
// and on the last byte classifies the message into a record.
// ----------------------------------------------------------------------------
module gcd_parser #(
	parameter int MSG_BYTES = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        byte_in,
	input  logic              last_in,
	output logic              push,
	output gcd_pkg::cmd_rec_t rec
);

	localparam int CNT_W = $clog2(MSG_BYTES + 1);

	logic [CNT_W-1:0] byte_cnt_q, byte_cnt_nxt;
	logic             comma_q, comma_nxt;
	logic             stopped_q, stopped_nxt;
	logic             closed_q, closed_nxt;
	logic [7:0]       cmd_q [gcd_pkg::CMD_CHARS];
	logic [7:0]       cmd_nxt [gcd_pkg::CMD_CHARS];
	logic [1:0]       cmd_len_q, cmd_len_nxt;
	logic [4:0]       dig_cnt_q, dig_cnt_nxt;
	logic             bad_q, bad_nxt;
	logic [31:0]      acc_q, acc_nxt;
	logic             is_digit;
	logic [31:0]      acc_times_ten;
	gcd_pkg::cmd_match_t match;

	assign is_digit      = (byte_in >= gcd_pkg::CH_ZERO) && (byte_in <= gcd_pkg::CH_NINE);
	assign acc_times_ten = {acc_q[28:0], 3'b000} + {acc_q[30:0], 1'b0};

	always_comb begin
		byte_cnt_nxt = byte_cnt_q;
		comma_nxt    = comma_q;
		stopped_nxt  = stopped_q;
		closed_nxt   = closed_q;
		cmd_nxt      = cmd_q;
		cmd_len_nxt  = cmd_len_q;
		dig_cnt_nxt  = dig_cnt_q;
		bad_nxt      = bad_q;
		acc_nxt      = acc_q;
		if (!stopped_q) begin
			if (byte_in == gcd_pkg::CH_CR) begin
				stopped_nxt = 1'b1;
			end else begin
				if (byte_in == gcd_pkg::CH_COMMA) begin
					comma_nxt = 1'b1;
				end else if (!comma_q) begin
					if (cmd_len_q < 2'(gcd_pkg::CMD_CHARS)) begin
						for (int i = 0; i < gcd_pkg::CMD_CHARS; i++) begin
							if (cmd_len_q == 2'(i)) begin
								cmd_nxt[i] = byte_in;
							end
						end
						cmd_len_nxt = cmd_len_q + 1'b1;
					end
				end else if (!closed_q) begin
					if (byte_in == gcd_pkg::CH_NUL) begin
						closed_nxt = 1'b1;
					end else begin
						if (is_digit) begin
							acc_nxt = acc_times_ten + {28'd0, byte_in[3:0]};
						end else begin
							bad_nxt = 1'b1;
						end
						if (dig_cnt_q != 5'(gcd_pkg::DIGIT_MAX)) begin
							dig_cnt_nxt = dig_cnt_q + 1'b1;
						end
					end
				end
				byte_cnt_nxt = byte_cnt_q + 1'b1;
				if (byte_cnt_nxt >= CNT_W'(MSG_BYTES)) begin
					stopped_nxt = 1'b1;
				end
			end
		end
	end

	// only a full three-character command can match
	always_comb begin
		match = gcd_pkg::cmd_lookup({cmd_nxt[0], cmd_nxt[1], cmd_nxt[2]});
		if (cmd_len_nxt != 2'(gcd_pkg::CMD_CHARS)) begin
			match = '0;
		end
	end

	assign push       = take && last_in;
	assign rec.known  = match.known;
	assign rec.sel    = match.sel;
	assign rec.num_ok = (dig_cnt_nxt != '0) && !bad_nxt;
	assign rec.value  = acc_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q <= '0;
			comma_q    <= 1'b0;
			stopped_q  <= 1'b0;
			closed_q   <= 1'b0;
			cmd_q      <= '{default: '0};
			cmd_len_q  <= '0;
			dig_cnt_q  <= '0;
			bad_q      <= 1'b0;
			acc_q      <= '0;
		end else if (take) begin
			if (last_in) begin
				byte_cnt_q <= '0;
				comma_q    <= 1'b0;
				stopped_q  <= 1'b0;
				closed_q   <= 1'b0;
				cmd_q      <= '{default: '0};
				cmd_len_q  <= '0;
				dig_cnt_q  <= '0;
				bad_q      <= 1'b0;
				acc_q      <= '0;
			end else begin
				byte_cnt_q <= byte_cnt_nxt;
				comma_q    <= comma_nxt;
				stopped_q  <= stopped_nxt;
				closed_q   <= closed_nxt;
				cmd_q      <= cmd_nxt;
				cmd_len_q  <= cmd_len_nxt;
				dig_cnt_q  <= dig_cnt_nxt;
				bad_q      <= bad_nxt;
				acc_q      <= acc_nxt;
			end
		end
	end

endmodule

// ----- design/gcd_issuer.sv -----
// ----------------------------------------------------------------------------
// gcd_issuer
// Back end: turns a classified record into a result, keeps the indicator
// and holds the result in the output register until it is taken.
// ----------------------------------------------------------------------------
module gcd_issuer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_avail,
	input  gcd_pkg::cmd_rec_t rec,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [39:0]       m_tdata
);

	logic        tvalid_q;
	logic        ind_q;
	logic        write_q;
	logic [1:0]  sel_q;
	logic [31:0] value_q;
	logic [1:0]  status_q;
	logic [1:0]  status;
	logic        accepted;

	assign pop      = rec_avail && (!tvalid_q || m_tready);
	assign accepted = rec.known && rec.num_ok;

	always_comb begin
		priority if (!rec.known) begin
			status = gcd_pkg::ST_UNKNOWN_CMD;
		end else if (!rec.num_ok) begin
			status = gcd_pkg::ST_BAD_NUMBER;
		end else begin
			status = gcd_pkg::ST_ACCEPTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= 1'b0;
			ind_q    <= 1'b0;
		end else begin
			if (pop) begin
				tvalid_q <= 1'b1;
				ind_q    <= ind_q ^ accepted;
			end else if (m_tready) begin
				tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			write_q  <= accepted;
			sel_q    <= rec.known ? rec.sel : 2'd0;
			value_q  <= accepted ? rec.value : 32'd0;
			status_q <= status;
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = {2'b00, ind_q, status_q, value_q, sel_q, write_q};

endmodule

// ----- design/gain_command_decoder_top.sv -----
// ----------------------------------------------------------------------------
// gain_command_decoder_top
// Decodes "CMD,NUMBER" gain commands arriving one byte per transaction.
// ----------------------------------------------------------------------------
// One message byte is taken per clock cycle while s_tready is high, with no
// gaps between messages. The parser updates the command and a times-ten
// accumulator in the cycle a byte arrives; on the byte with tlast it
// classifies the message and places a record in a two-entry queue. The issuer
// drains that queue into the output register, so each result passes through a
// queue entry and the output register; the slave side only stalls when both
// queue entries are still waiting behind an unaccepted result.
module gain_command_decoder_top #(
	parameter int MSG_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,	// msg_byte[7:0]
	input  logic        s_tlast,	// msg_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata	// write_valid, gain_select[1:0], gain_value[31:0],
					// decode_status[1:0], indicator, zero pad
);

	logic              take;
	logic              push;
	logic              pop;
	logic              q_full;
	logic              q_empty;
	gcd_pkg::cmd_rec_t rec_in;
	gcd_pkg::cmd_rec_t rec_out;

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	gcd_parser #(
		.MSG_BYTES(MSG_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.byte_in (s_tdata),
		.last_in (s_tlast),
		.push    (push),
		.rec     (rec_in)
	);

	gcd_queue #(
		.WIDTH($bits(gcd_pkg::cmd_rec_t)),
		.DEPTH(gcd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (rec_in),
		.pop     (pop),
		.rd_data (rec_out),
		.full    (q_full),
		.empty   (q_empty)
	);

	gcd_issuer u_issuer (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_avail (!q_empty),
		.rec       (rec_out),
		.pop       (pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ----- design/gcd_checker.sv -----
// ----------------------------------------------------------------------------
// gcd_checker
// Port-level checks of the gain command decoder results.
// ----------------------------------------------------------------------------
module gcd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// write flag agrees with status
	a_write_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[0] == (m_tdata[36:35] == 2'd0)))
		else $error("write flag does not match status");

	// no value without a write
	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> (m_tdata[34:3] == 32'd0))
		else $error("value shown on rejected command");

	// unknown command selects no gain
	a_unknown_sel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[36:35] == 2'd1) |-> (m_tdata[2:1] == 2'd0))
		else $error("gain selected on unknown command");

	// a result only follows a last byte
	a_needs_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2) || $past(m_tvalid, 2)
			|| $past(!s_tready, 2) || $past(!s_tready, 1))
		else $error("result without a message end");

endmodule

bind gain_command_decoder_top gcd_checker u_gcd_checker (.*);

// ----- dv/tb_gain_command_decoder_top.sv -----
// ----------------------------------------------------------------------------
// tb_gain_command_decoder_top
// Self-checking bench for the gain command decoder. A short table of hand-built
// messages runs first, then random messages, mostly well-formed gain commands
// with random digits and end markers mixed in, plus pure noise. Every accepted
// byte goes through a local decoder model; each result transaction is checked
// field by field against the oldest expected result. Both sides idle at random,
// the sink holds off once for a long stretch, and the source drains once.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gain_command_decoder_top;

	localparam int MSG_BYTES  = 16;
	localparam int RAND_ITEMS = 1800;
	localparam int CYCLE_MAX  = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 10;

	typedef struct packed {
		logic        wr;
		logic [1:0]  sel;
		logic [31:0] val;
		logic [1:0]  status;
		logic        ind;
	} gain_res_t;

	typedef struct packed {
		logic [7:0] b;
		logic       last;
		logic       typed;	// row carries its own expected result
		gain_res_t  res;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;

	gain_command_decoder_top #(
		.MSG_BYTES(MSG_BYTES)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// directed messages: plain write, long command, joined digits with a cr,
	// non-digit in the number, lone zero byte without a comma
	dir_row_t dir_rows [26] = '{
		'{"K", 1'b0, 1'b0, '0},
		'{"p", 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{",", 1'b0, 1'b0, '0},
		'{"9", 1'b1, 1'b1, '{1'b1, 2'd0, 32'd9, gcd_pkg::ST_ACCEPTED, 1'b1}},
		'{"K", 1'b0, 1'b0, '0},
		'{"p", 1'b0, 1'b0, '0},
		'{"2", 1'b0, 1'b0, '0},
		'{"2", 1'b0, 1'b0, '0},
		'{",", 1'b0, 1'b0, '0},
		'{"1", 1'b1, 1'b0, '0},
		'{"X", 1'b0, 1'b0, '0},
		'{"*", 1'b0, 1'b0, '0},
		'{"*", 1'b0, 1'b0, '0},
		'{",", 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{",", 1'b0, 1'b0, '0},
		'{"2", 1'b0, 1'b0, '0},
		'{gcd_pkg::CH_CR, 1'b0, 1'b0, '0},
		'{"7", 1'b1, 1'b0, '0},
		'{"K", 1'b0, 1'b0, '0},
		'{"i", 1'b0, 1'b0, '0},
		'{"1", 1'b0, 1'b0, '0},
		'{",", 1'b0, 1'b0, '0},
		'{8'hFF, 1'b1, 1'b1, '{1'b0, 2'd2, 32'd0, gcd_pkg::ST_BAD_NUMBER, 1'b1}},
		'{gcd_pkg::CH_NUL, 1'b1, 1'b1, '{1'b0, 2'd0, 32'd0, gcd_pkg::ST_UNKNOWN_CMD, 1'b1}}
	};

	// decoder model state
	int          mdl_byte_cnt;
	bit          mdl_comma;
	bit          mdl_stopped;
	bit          mdl_closed;
	logic [7:0]  mdl_cmd [3];
	int          mdl_cmd_len;
	int          mdl_digits;
	bit          mdl_bad;
	logic [31:0] mdl_acc;
	logic        mdl_ind;

	gain_res_t   gain_res_q [$];
	int          err_cnt;
	int          cycle_cnt;
	int          n_items;
	int          n_msgs;
	int          n_results;
	int          n_written;
	int          n_unknown;
	int          n_bad_num;
	bit          src_idle_en;
	bit          sink_idle_en;
	bit          hold_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		err_cnt++;
	endtask

	task automatic clear_model_msg();
		mdl_byte_cnt = 0;
		mdl_comma    = 1'b0;
		mdl_stopped  = 1'b0;
		mdl_closed   = 1'b0;
		mdl_cmd      = '{8'h00, 8'h00, 8'h00};
		mdl_cmd_len  = 0;
		mdl_digits   = 0;
		mdl_bad      = 1'b0;
		mdl_acc      = '0;
	endtask

	// advance the model by one accepted byte; a result comes out on the last byte
	task automatic decode_byte(input logic [7:0] b, input logic last, output bit got,
			output gain_res_t r);
		bit known;
		logic [1:0] sel;
		known = 1'b0;
		sel   = 2'd0;
		got   = 1'b0;
		r     = '0;
		if (!mdl_stopped) begin
			if (b == gcd_pkg::CH_CR) begin
				mdl_stopped = 1'b1;
			end else begin
				if (b == gcd_pkg::CH_COMMA) begin
					mdl_comma = 1'b1;
				end else if (!mdl_comma) begin
					if (mdl_cmd_len < 3) begin
						mdl_cmd[mdl_cmd_len] = b;
						mdl_cmd_len++;
					end
				end else if (!mdl_closed) begin
					if (b == gcd_pkg::CH_NUL) begin
						mdl_closed = 1'b1;
					end else begin
						if (b >= gcd_pkg::CH_ZERO && b <= gcd_pkg::CH_NINE)
							mdl_acc = mdl_acc * 32'd10 + 32'(b - gcd_pkg::CH_ZERO);
						else
							mdl_bad = 1'b1;
						if (mdl_digits < 31)
							mdl_digits++;
					end
				end
				mdl_byte_cnt++;
				if (mdl_byte_cnt >= MSG_BYTES)
					mdl_stopped = 1'b1;
			end
		end
		if (last) begin
			if (mdl_cmd_len == 3) begin
				known = 1'b1;
				unique case ({mdl_cmd[0], mdl_cmd[1], mdl_cmd[2]})
					"Kp1": sel = 2'd0;
					"Kp2": sel = 2'd1;
					"Ki1": sel = 2'd2;
					"Ki2": sel = 2'd3;
					"X**": sel = 2'd3;
					default: known = 1'b0;
				endcase
			end
			if (!known) begin
				r.status = gcd_pkg::ST_UNKNOWN_CMD;
			end else begin
				r.sel = sel;
				if (mdl_digits == 0 || mdl_bad) begin
					r.status = gcd_pkg::ST_BAD_NUMBER;
				end else begin
					r.status = gcd_pkg::ST_ACCEPTED;
					r.wr     = 1'b1;
					r.val    = mdl_acc;
					mdl_ind  = ~mdl_ind;
				end
			end
			r.ind = mdl_ind;
			got   = 1'b1;
			clear_model_msg();
		end
	endtask

	// offer one byte, idling first at random, and wait for the handshake
	task automatic push_byte(input logic [7:0] b, input logic last, input bit typed,
			input gain_res_t typed_res);
		bit got;
		gain_res_t r;
		while (src_idle_en && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		n_items++;
		decode_byte(b, last, got, r);
		if (got) begin
			if (typed)
				r = typed_res;
			gain_res_q.push_back(r);
			n_msgs++;
			unique case (r.status)
				gcd_pkg::ST_ACCEPTED:    n_written++;
				gcd_pkg::ST_UNKNOWN_CMD: n_unknown++;
				default:                 n_bad_num++;
			endcase
		end
	endtask

	task automatic build_msg(output logic [7:0] m [$]);
		int kind;
		int nd;
		int pick;
		logic [23:0] cmd;
		string big;
		string cmd_alpha;
		m = {};
		kind = $urandom_range(99);
		cmd_alpha = "Kpi12X*";
		if (kind < 70) begin
			case ($urandom_range(4))
				0: cmd = "Kp1";
				1: cmd = "Kp2";
				2: cmd = "Ki1";
				3: cmd = "Ki2";
				default: cmd = "X**";
			endcase
			if ($urandom_range(9) == 0)
				cmd[$urandom_range(2) * 8 +: 8] = 8'($urandom);
			m.push_back(cmd[23:16]);
			m.push_back(cmd[15:8]);
			if ($urandom_range(9) != 0)
				m.push_back(cmd[7:0]);
			if ($urandom_range(9) == 0)
				m.push_back(8'($urandom));
			if ($urandom_range(19) != 0)
				m.push_back(gcd_pkg::CH_COMMA);
			if ($urandom_range(19) == 0) begin
				// top of the 32-bit range and the first value that wraps
				if ($urandom_range(1) != 0)
					big = "4294967295";
				else
					big = "4294967296";
				for (int i = 0; i < big.len(); i++)
					m.push_back(big[i]);
			end else begin
				nd = ($urandom_range(9) == 0) ? $urandom_range(11, 14) : $urandom_range(0, 10);
				for (int i = 0; i < nd; i++) begin
					pick = $urandom_range(49);
					if (pick == 0)
						m.push_back(gcd_pkg::CH_COMMA);
					else if (pick == 1)
						m.push_back(8'($urandom));
					else if (pick == 2)
						m.push_back(gcd_pkg::CH_NUL);
					else if (pick == 3)
						m.push_back(gcd_pkg::CH_CR);
					else
						m.push_back(8'(gcd_pkg::CH_ZERO + $urandom_range(9)));
				end
			end
			if ($urandom_range(9) == 0) begin
				m.push_back($urandom_range(1) ? gcd_pkg::CH_CR : gcd_pkg::CH_NUL);
				repeat ($urandom_range(3))
					m.push_back(8'($urandom));
			end
		end else begin
			nd = $urandom_range(1, 20);
			repeat (nd) begin
				pick = $urandom_range(9);
				if (pick < 4)
					m.push_back(8'($urandom));
				else if (pick < 6)
					m.push_back(8'(gcd_pkg::CH_ZERO + $urandom_range(9)));
				else if (pick == 6)
					m.push_back(gcd_pkg::CH_COMMA);
				else if (pick == 7)
					m.push_back(gcd_pkg::CH_CR);
				else if (pick == 8)
					m.push_back(gcd_pkg::CH_NUL);
				else
					m.push_back(cmd_alpha[$urandom_range(6)]);
			end
		end
	endtask

	// sink side: random backpressure, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		while (!arst_n)
			@(posedge clk);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (sink_idle_en) begin
				m_tready <= ($urandom_range(99) >= 30);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		gain_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (gain_res_q.size() == 0) begin
				report_mismatch("result with none outstanding", m_tdata[31:0], '0);
			end else begin
				want = gain_res_q.pop_front();
				if (m_tdata[0] !== want.wr)
					report_mismatch("write_valid", 32'(m_tdata[0]), 32'(want.wr));
				if (m_tdata[2:1] !== want.sel)
					report_mismatch("gain_select", 32'(m_tdata[2:1]), 32'(want.sel));
				if (m_tdata[34:3] !== want.val)
					report_mismatch("gain_value", m_tdata[34:3], want.val);
				if (m_tdata[36:35] !== want.status)
					report_mismatch("decode_status", 32'(m_tdata[36:35]),
						32'(want.status));
				if (m_tdata[37] !== want.ind)
					report_mismatch("indicator", 32'(m_tdata[37]), 32'(want.ind));
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_MAX) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				gain_res_q.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		logic [7:0] msg [$];
		int msg_idx;
		int rand_start;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		err_cnt      = 0;
		cycle_cnt    = 0;
		n_items      = 0;
		n_msgs       = 0;
		n_results    = 0;
		n_written    = 0;
		n_unknown    = 0;
		n_bad_num    = 0;
		hold_req     = 1'b0;
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
		mdl_ind      = 1'b0;
		clear_model_msg();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			push_byte(dir_rows[i].b, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].res);

		rand_start = n_items;
		msg_idx = 0;
		while (n_items - rand_start < RAND_ITEMS) begin
			// quiet window with no idling on either side
			src_idle_en  = !(msg_idx >= 60 && msg_idx < 90);
			sink_idle_en = src_idle_en;
			if (msg_idx == 30)
				hold_req = 1'b1;
			if (msg_idx == 120) begin
				// source drains: no bytes until every result is back
				s_tvalid <= 1'b0;
				while (gain_res_q.size() != 0)
					@(posedge clk);
			end
			build_msg(msg);
			for (int i = 0; i < msg.size(); i++)
				push_byte(msg[i], i == msg.size() - 1, 1'b0, '0);
			msg_idx++;
		end
		s_tvalid <= 1'b0;

		while (gain_res_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d messages over %0d cycles, %0d results seen",
			n_items, n_msgs, cycle_cnt, n_results);
		$display("writes %0d, unknown commands %0d, bad numbers %0d, mismatches %0d",
			n_written, n_unknown, n_bad_num, err_cnt);
		if (err_cnt == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
